>>> design/wcm_pkg.sv
// Shared constants and types for the three-channel window mean unit.
`timescale 1ns / 1ps
`default_nettype none
package wcm_pkg;

  localparam int NUM_CH         = 3;
  localparam int SAMPLE_W       = 16;
  localparam int WIN_CFG_W      = 7;
  localparam int MAX_WINDOW_DEF = 64;

  localparam logic [WIN_CFG_W-1:0] WINDOW_RESET = 7'd64;

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_DIV
  } wcm_state_t;

endpackage : wcm_pkg
`default_nettype wire

>>> design/wcm_in_if.sv
// Input channel: one sample vector or a clear action per word.
`timescale 1ns / 1ps
`default_nettype none
interface wcm_in_if;
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic signed [15:0]   sample_magnitude;
  logic signed [15:0]   sample_alpha;
  logic signed [15:0]   sample_beta;

  modport source (output valid, action, sample_magnitude, sample_alpha, sample_beta,
                  input ready);
  modport sink   (input valid, action, sample_magnitude, sample_alpha, sample_beta,
                  output ready);
endinterface : wcm_in_if
`default_nettype wire

>>> design/wcm_out_if.sv
// Result channel: the three window means per word.
`timescale 1ns / 1ps
`default_nettype none
interface wcm_out_if;
  logic                 valid;
  logic                 ready;
  logic signed [15:0]   mean_magnitude;
  logic signed [15:0]   mean_alpha;
  logic signed [15:0]   mean_beta;

  modport source (output valid, mean_magnitude, mean_alpha, mean_beta, input ready);
  modport sink   (input valid, mean_magnitude, mean_alpha, mean_beta, output ready);
endinterface : wcm_out_if
`default_nettype wire

>>> design/wcm_cfg_if.sv
// Configuration write channel for the window size register.
`timescale 1ns / 1ps
`default_nettype none
interface wcm_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] window_size;

  modport source (output valid, window_size, input ready);
  modport sink   (input valid, window_size, output ready);
endinterface : wcm_cfg_if
`default_nettype wire

>>> design/three_channel_window_mean_unit.sv
// Top level: window mean over a ring of three-channel samples.
//
//   channel  dir  payload                                         handshake
//   in_ch    in   action, sample_magnitude/alpha/beta (s16 each)  valid/ready
//   out_ch   out  mean_magnitude/alpha/beta (s16 each)            valid/ready
//   cfg_ch   in   window_size (u7)                                valid/ready
//
// Push word: the ring memory is swept over the effective window W (one read
// per cycle), then the bit-serial divider forms the means; in_ch.ready rises
// again once the result is loaded into the output register.
// Clear word: a zeroing pass over the memory, then the same sweep and division.
// After reset a zeroing pass over the whole memory runs before in_ch.ready rises.
// in_ch is taken only when idle; a held result in the output register stalls
// only the final step of the next word. cfg_ch is always ready.
`timescale 1ns / 1ps
`default_nettype none
module three_channel_window_mean_unit #(
  parameter int MAX_WINDOW = wcm_pkg::MAX_WINDOW_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  wcm_in_if.sink    in_ch,
  wcm_out_if.source out_ch,
  wcm_cfg_if.sink   cfg_ch
);

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int DIV_W = PTR_W + 1;
  localparam int SUM_W = wcm_pkg::SAMPLE_W + PTR_W;
  localparam logic [PTR_W-1:0] LAST_ADDR = PTR_W'(MAX_WINDOW - 1);
  localparam logic [DIV_W-1:0] MAX_W     = DIV_W'(MAX_WINDOW);

  wcm_pkg::wcm_state_t state_r, state_nxt;

  logic [wcm_pkg::WIN_CFG_W-1:0]                         win_r;
  logic [PTR_W-1:0]                                      wp_r;
  logic [PTR_W-1:0]                                      clr_cnt_r;
  logic                                                  started_r;
  logic [DIV_W-1:0]                                      rd_cnt_r;
  logic                                                  rd_vld_r;
  logic [wcm_pkg::NUM_CH-1:0][SUM_W-1:0]                 acc_r;
  logic [wcm_pkg::NUM_CH-1:0][wcm_pkg::SAMPLE_W-1:0]     mean_r;
  logic                                                  out_valid_r;

  logic [31:0]                                           win_ext;
  logic [DIV_W-1:0]                                      eff_w;
  logic                                                  in_acc;
  logic [PTR_W-1:0]                                      push_addr;
  logic [DIV_W-1:0]                                      push_inc;
  logic                                                  mem_we;
  logic [PTR_W-1:0]                                      mem_waddr;
  logic [wcm_pkg::NUM_CH-1:0][wcm_pkg::SAMPLE_W-1:0]     mem_wdata;
  logic                                                  mem_re;
  logic [wcm_pkg::NUM_CH-1:0][wcm_pkg::SAMPLE_W-1:0]     mem_rdata;
  logic                                                  sum_done;
  logic                                                  div_busy;
  logic [wcm_pkg::NUM_CH-1:0][wcm_pkg::SAMPLE_W-1:0]     div_q;
  logic                                                  out_load;

  // window size register, clamped to 1..MAX_WINDOW
  assign win_ext = {25'b0, win_r};
  always_comb begin
    if (win_r == '0) begin
      eff_w = DIV_W'(1);
    end else if (win_ext > 32'(MAX_WINDOW)) begin
      eff_w = MAX_W;
    end else begin
      eff_w = win_ext[DIV_W-1:0];
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == wcm_pkg::ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;

  // pointer left beyond a shrunk window restarts at zero
  assign push_addr = ({1'b0, wp_r} >= eff_w) ? '0 : wp_r;
  assign push_inc  = {1'b0, push_addr} + 1'b1;

  assign mem_we    = (state_r == wcm_pkg::ST_CLEAR) ||
                     (in_acc && (in_ch.action == wcm_pkg::ACT_PUSH));
  assign mem_waddr = (state_r == wcm_pkg::ST_CLEAR) ? clr_cnt_r : push_addr;
  assign mem_wdata = (state_r == wcm_pkg::ST_CLEAR) ? '0 :
                     {in_ch.sample_beta, in_ch.sample_alpha, in_ch.sample_magnitude};
  assign mem_re    = (state_r == wcm_pkg::ST_SUM) && (rd_cnt_r < eff_w);
  assign sum_done  = (state_r == wcm_pkg::ST_SUM) && (rd_cnt_r == eff_w) && !rd_vld_r;
  assign out_load  = (state_r == wcm_pkg::ST_DIV) && !div_busy &&
                     (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wcm_pkg::ST_CLEAR: begin
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = started_r ? wcm_pkg::ST_SUM : wcm_pkg::ST_IDLE;
        end
      end
      wcm_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_ch.action == wcm_pkg::ACT_CLEAR) ? wcm_pkg::ST_CLEAR
                                                           : wcm_pkg::ST_SUM;
        end
      end
      wcm_pkg::ST_SUM: begin
        if (sum_done) begin
          state_nxt = wcm_pkg::ST_DIV;
        end
      end
      wcm_pkg::ST_DIV: begin
        if (out_load) begin
          state_nxt = wcm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wcm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wcm_pkg::ST_CLEAR;
      win_r       <= wcm_pkg::WINDOW_RESET;
      wp_r        <= '0;
      clr_cnt_r   <= '0;
      started_r   <= 1'b0;
      rd_cnt_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        win_r <= cfg_ch.window_size;
      end
      if (in_acc) begin
        started_r <= 1'b1;
        if (in_ch.action == wcm_pkg::ACT_PUSH) begin
          wp_r <= (push_inc >= eff_w) ? '0 : push_inc[PTR_W-1:0];
        end
      end
      clr_cnt_r <= (state_r == wcm_pkg::ST_CLEAR) ? clr_cnt_r + 1'b1 : '0;
      if (state_r == wcm_pkg::ST_SUM) begin
        rd_vld_r <= mem_re;
        if (mem_re) begin
          rd_cnt_r <= rd_cnt_r + 1'b1;
        end
      end else begin
        rd_vld_r <= 1'b0;
        rd_cnt_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // window sums, one memory word per cycle
  always_ff @(posedge clk) begin
    if (state_r != wcm_pkg::ST_SUM) begin
      acc_r <= '0;
    end else if (rd_vld_r) begin
      for (int c = 0; c < wcm_pkg::NUM_CH; c++) begin
        acc_r[c] <= acc_r[c] + {{(SUM_W - wcm_pkg::SAMPLE_W){mem_rdata[c][wcm_pkg::SAMPLE_W-1]}},
                                mem_rdata[c]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mean_r <= div_q;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.mean_magnitude = mean_r[0];
  assign out_ch.mean_alpha     = mean_r[1];
  assign out_ch.mean_beta      = mean_r[2];

  wcm_store #(
    .DEPTH  (MAX_WINDOW),
    .ADDR_W (PTR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (rd_cnt_r[PTR_W-1:0]),
    .rd_data (mem_rdata)
  );

  wcm_div #(
    .SUM_W (SUM_W),
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sum_done),
    .divisor  (eff_w),
    .dividend (acc_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

endmodule : three_channel_window_mean_unit
`default_nettype wire

>>> design/wcm_store.sv
// Sample ring memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module wcm_store #(
  parameter int DEPTH  = wcm_pkg::MAX_WINDOW_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                                          clk,
  input  wire logic                                          wr_en,
  input  wire logic [ADDR_W-1:0]                             wr_addr,
  input  wire logic [wcm_pkg::NUM_CH-1:0][wcm_pkg::SAMPLE_W-1:0] wr_data,
  input  wire logic                                          rd_en,
  input  wire logic [ADDR_W-1:0]                             rd_addr,
  output logic      [wcm_pkg::NUM_CH-1:0][wcm_pkg::SAMPLE_W-1:0] rd_data
);

  logic [wcm_pkg::NUM_CH-1:0][wcm_pkg::SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : wcm_store
`default_nettype wire

>>> design/wcm_div.sv
// Iterative signed divider, three lanes sharing one step counter, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module wcm_div #(
  parameter int SUM_W = 22,
  parameter int DIV_W = 7
) (
  input  wire logic                                              clk,
  input  wire logic                                              rst_n,
  input  wire logic                                              start,
  input  wire logic [DIV_W-1:0]                                  divisor,
  input  wire logic [wcm_pkg::NUM_CH-1:0][SUM_W-1:0]             dividend,
  output logic                                                   busy,
  output logic      [wcm_pkg::NUM_CH-1:0][wcm_pkg::SAMPLE_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0]                        cnt_r;
  logic                                    busy_r;
  logic [DIV_W-1:0]                        d_r;
  logic [wcm_pkg::NUM_CH-1:0]              neg_r;
  logic [wcm_pkg::NUM_CH-1:0][SUM_W-1:0]   q_r;
  logic [wcm_pkg::NUM_CH-1:0][DIV_W-1:0]   rem_r;
  logic [wcm_pkg::NUM_CH-1:0][SUM_W-1:0]   q_nxt;
  logic [wcm_pkg::NUM_CH-1:0][DIV_W-1:0]   rem_nxt;
  logic [wcm_pkg::NUM_CH-1:0][SUM_W-1:0]   mag;

  assign busy = busy_r;

  always_comb begin
    for (int c = 0; c < wcm_pkg::NUM_CH; c++) begin
      logic [DIV_W:0] shifted;
      logic [DIV_W:0] diff;
      shifted = {rem_r[c], q_r[c][SUM_W-1]};
      diff    = shifted - {1'b0, d_r};
      mag[c]  = dividend[c][SUM_W-1] ? (~dividend[c] + 1'b1) : dividend[c];
      if (shifted >= {1'b0, d_r}) begin
        rem_nxt[c] = diff[DIV_W-1:0];
        q_nxt[c]   = {q_r[c][SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt[c] = shifted[DIV_W-1:0];
        q_nxt[c]   = {q_r[c][SUM_W-2:0], 1'b0};
      end
      // |quotient| never exceeds 32768, so the low bits carry it whole
      quotient[c] = neg_r[c] ? (~q_r[c][wcm_pkg::SAMPLE_W-1:0] + 1'b1)
                             : q_r[c][wcm_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(SUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r <= divisor;
      for (int c = 0; c < wcm_pkg::NUM_CH; c++) begin
        neg_r[c] <= dividend[c][SUM_W-1];
        q_r[c]   <= mag[c];
        rem_r[c] <= '0;
      end
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule : wcm_div
`default_nettype wire

>>> tb/sv/tb_three_channel_window_mean_unit.sv
// Self-checking bench for the three-channel window mean unit: random traffic, windows, stalls.
`timescale 1ns / 1ps
module tb_three_channel_window_mean_unit;

  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          RANDOM_WORDS = 1125;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          SETTLE       = 4;
  localparam int          TAIL         = 300;
  localparam logic [15:0] S_MAX        = 16'sh7FFF;
  localparam logic [15:0] S_MIN        = 16'sh8000;

  typedef struct packed {
    logic signed [15:0] mag;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
  } vec3_t;

  typedef enum logic [1:0] {JOB_WORD, JOB_CFG, JOB_DRAIN} job_kind_t;

  typedef struct {
    job_kind_t      kind;
    logic           act;
    vec3_t          smp;
    logic [6:0]     win;
  } job_t;

  logic clk;
  logic rst_n;

  wcm_in_if  in_ch ();
  wcm_out_if out_ch ();
  wcm_cfg_if cfg_ch ();

  three_channel_window_mean_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predictor state
  vec3_t       ring [wcm_pkg::MAX_WINDOW_DEF];
  int          wr_ptr;
  logic [6:0]  win_reg;

  job_t        job_q [$];
  vec3_t       mean_q [$];

  int unsigned n_err       = 0;
  int unsigned n_results   = 0;
  int unsigned words_taken = 0;
  int unsigned src_wait    = 0;
  int unsigned src_calm    = 0;
  int unsigned sink_wait   = 0;
  int unsigned sink_calm   = 0;
  int unsigned quiet       = 0;
  int unsigned hold_left   = 0;
  int unsigned hold_mark   = 250;
  int unsigned cycle_cnt   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One push or clear through the ring; returns the three truncated window means.
  function automatic vec3_t step_window(input logic act, input vec3_t smp);
    int    w;
    longint sm;
    longint sa;
    longint sb;
    vec3_t r;
    w = (win_reg == 7'd0) ? 1 :
        ((win_reg > wcm_pkg::MAX_WINDOW_DEF) ? wcm_pkg::MAX_WINDOW_DEF : int'(win_reg));
    if (act == wcm_pkg::ACT_CLEAR) begin
      foreach (ring[i]) ring[i] = '0;
    end else begin
      // pointer left beyond a shrunk window goes back to the start first
      if (wr_ptr >= w) wr_ptr = 0;
      ring[wr_ptr] = smp;
      wr_ptr++;
      if (wr_ptr >= w) wr_ptr = 0;
    end
    sm = 0;
    sa = 0;
    sb = 0;
    for (int i = 0; i < w; i++) begin
      sm += ring[i].mag;
      sa += ring[i].alpha;
      sb += ring[i].beta;
    end
    r.mag   = 16'(sm / longint'(w));
    r.alpha = 16'(sa / longint'(w));
    r.beta  = 16'(sb / longint'(w));
    return r;
  endfunction

  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [15:0] rand_field(input int mode);
    logic [15:0] pick [5];
    pick = '{S_MAX, S_MIN, 16'h0000, 16'hFFFF, 16'h0001};
    if (mode == 1) return ($urandom_range(0, 7) != 0) ? S_MAX : 16'($urandom);
    if (mode == 2) return ($urandom_range(0, 7) != 0) ? S_MIN : 16'($urandom);
    if ($urandom_range(0, 5) == 0) return pick[$urandom_range(0, 4)];
    return 16'($urandom);
  endfunction

  function automatic void push_word(input logic act, input logic [15:0] m,
                                    input logic [15:0] a, input logic [15:0] b);
    job_t j;
    j.kind = JOB_WORD;
    j.act  = act;
    j.smp  = {m, a, b};
    j.win  = '0;
    job_q.push_back(j);
  endfunction

  function automatic void push_cfg(input logic [6:0] w);
    job_t j;
    j.kind = JOB_CFG;
    j.act  = wcm_pkg::ACT_PUSH;
    j.smp  = '0;
    j.win  = w;
    job_q.push_back(j);
  endfunction

  function automatic void push_drain();
    job_t j;
    j.kind = JOB_DRAIN;
    j.act  = wcm_pkg::ACT_PUSH;
    j.smp  = '0;
    j.win  = '0;
    job_q.push_back(j);
  endfunction

  task automatic report_mismatch(input string what, input logic signed [15:0] got,
                                 input logic signed [15:0] want);
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_results);
    n_err++;
  endtask

  task automatic check_means();
    vec3_t want;
    if (mean_q.size() == 0) begin
      report_mismatch("unexpected result word", out_ch.mean_magnitude, 16'sd0);
    end else begin
      want = mean_q.pop_front();
      if (out_ch.mean_magnitude !== want.mag)
        report_mismatch("mean_magnitude", out_ch.mean_magnitude, want.mag);
      if (out_ch.mean_alpha !== want.alpha)
        report_mismatch("mean_alpha", out_ch.mean_alpha, want.alpha);
      if (out_ch.mean_beta !== want.beta)
        report_mismatch("mean_beta", out_ch.mean_beta, want.beta);
    end
    n_results++;
  endtask

  // Sender: input words and window writes, fed from job_q.
  always @(posedge clk) begin : drive_words
    logic        in_v;
    logic        cfg_v;
    int unsigned gap;
    job_t        j;
    vec3_t       smp;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      cfg_ch.valid <= 1'b0;
      src_wait     <= 0;
      quiet        <= 0;
    end else begin
      in_v  = in_ch.valid;
      cfg_v = cfg_ch.valid;
      gap   = src_wait;
      if (in_ch.valid && in_ch.ready) begin
        smp.mag   = in_ch.sample_magnitude;
        smp.alpha = in_ch.sample_alpha;
        smp.beta  = in_ch.sample_beta;
        mean_q.push_back(step_window(in_ch.action, smp));
        words_taken <= words_taken + 1;
        in_v = 1'b0;
        gap  = draw_gap(src_calm);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        win_reg = cfg_ch.window_size;
        cfg_v   = 1'b0;
      end
      if (!in_v && !cfg_v) begin
        if (gap != 0) begin
          gap--;
        end else if (job_q.size() != 0) begin
          j = job_q[0];
          case (j.kind)
            JOB_WORD: begin
              void'(job_q.pop_front());
              in_ch.action           <= j.act;
              in_ch.sample_magnitude <= j.smp.mag;
              in_ch.sample_alpha     <= j.smp.alpha;
              in_ch.sample_beta      <= j.smp.beta;
              in_v = 1'b1;
            end
            JOB_DRAIN: begin
              if (mean_q.size() == 0) void'(job_q.pop_front());
            end
            JOB_CFG: begin
              // window changes only once the unit is idle with nothing in flight
              if (mean_q.size() == 0 && in_ch.ready && quiet >= SETTLE) begin
                void'(job_q.pop_front());
                cfg_ch.window_size <= j.win;
                cfg_v = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      if (mean_q.size() == 0 && !in_v && in_ch.ready) quiet <= quiet + 1;
      else quiet <= 0;
      src_wait     <= gap;
      in_ch.valid  <= in_v;
      cfg_ch.valid <= cfg_v;
    end
  end

  // Long receiver hold-offs so the unit backs up and stalls its input.
  always @(posedge clk) begin : hold_off
    if (rst_n) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (words_taken >= hold_mark) begin
        hold_left <= HOLD_CYCLES;
        hold_mark <= hold_mark + 500;
      end
    end
  end

  // Receiver: random stalls per word, checks each accepted result.
  always @(posedge clk) begin : take_results
    int unsigned nxt;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_wait    <= 0;
    end else begin
      nxt = sink_wait;
      if (out_ch.valid && out_ch.ready) begin
        check_means();
        nxt = draw_gap(sink_calm);
      end else if (nxt != 0) begin
        nxt--;
      end
      sink_wait    <= nxt;
      out_ch.ready <= (nxt == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned n_rand;
    int unsigned len;
    int          mode;
    int          r;
    logic [6:0]  w;
    logic [6:0]  corner [6];

    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.action           = wcm_pkg::ACT_PUSH;
    in_ch.sample_magnitude = '0;
    in_ch.sample_alpha     = '0;
    in_ch.sample_beta      = '0;
    out_ch.ready           = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.window_size     = wcm_pkg::WINDOW_RESET;
    foreach (ring[i]) ring[i] = '0;
    wr_ptr  = 0;
    win_reg = wcm_pkg::WINDOW_RESET;
    corner  = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd65, 7'd127};

    // directed: reset window of 64 first
    push_word(wcm_pkg::ACT_PUSH, S_MAX, S_MIN, 16'h0001);
    push_word(wcm_pkg::ACT_PUSH, S_MIN, S_MAX, 16'hFFFF);  // sums of -1 truncate to zero
    push_word(wcm_pkg::ACT_PUSH, 16'h5555, 16'hAAAA, 16'h00FF);
    push_word(wcm_pkg::ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_word(wcm_pkg::ACT_PUSH, -16'sd100, 16'sd100, -16'sd63);
    push_drain();
    // zero window acts as one
    push_cfg(7'd0);
    push_word(wcm_pkg::ACT_PUSH, S_MIN, S_MAX, -16'sd5);
    push_word(wcm_pkg::ACT_PUSH, 16'd1, 16'd2, 16'd3);
    push_word(wcm_pkg::ACT_CLEAR, 16'h1234, 16'hFEDC, 16'h8001);
    push_word(wcm_pkg::ACT_PUSH, 16'hFFFF, 16'h0000, 16'h0001);
    // grow without clear, then shrink below the write pointer
    push_cfg(7'd5);
    push_word(wcm_pkg::ACT_PUSH, 16'd700, -16'sd700, 16'd7);
    push_word(wcm_pkg::ACT_PUSH, 16'd800, -16'sd800, 16'd8);
    push_word(wcm_pkg::ACT_PUSH, 16'd900, -16'sd900, 16'd9);
    push_word(wcm_pkg::ACT_PUSH, S_MAX, S_MIN, S_MAX);
    push_cfg(7'd2);
    push_word(wcm_pkg::ACT_PUSH, 16'h00AA, 16'hFF55, 16'h7F00);
    // oversized windows saturate; old entries stay in the average
    push_cfg(7'd127);
    push_word(wcm_pkg::ACT_PUSH, 16'h8000, 16'h7FFF, 16'h0F0F);
    push_word(wcm_pkg::ACT_PUSH, 16'hF0F0, 16'h3333, 16'hCCCC);
    push_cfg(7'd65);
    push_word(wcm_pkg::ACT_PUSH, -16'sd1, 16'sd1, S_MIN);
    push_cfg(7'd1);
    push_word(wcm_pkg::ACT_PUSH, 16'h4000, 16'hC000, 16'h0080);

    // full window at both rails
    push_cfg(7'd64);
    push_word(wcm_pkg::ACT_CLEAR, 16'h0, 16'h0, 16'h0);
    repeat (66) push_word(wcm_pkg::ACT_PUSH, rand_field(1), rand_field(1), rand_field(1));
    repeat (66) push_word(wcm_pkg::ACT_PUSH, rand_field(2), rand_field(2), rand_field(2));
    n_rand = 133;

    while (n_rand < RANDOM_WORDS) begin
      r = $urandom_range(0, 9);
      if (r == 0) w = ($urandom_range(0, 6) == 6) ? 7'($urandom_range(66, 126))
                                                   : corner[$urandom_range(0, 5)];
      else if (r <= 6) w = 7'($urandom_range(1, 8));
      else if (r <= 8) w = 7'($urandom_range(9, 40));
      else w = 7'($urandom_range(41, 64));
      push_cfg(w);
      if ($urandom_range(0, 1) == 0) begin
        push_word(wcm_pkg::ACT_CLEAR, rand_field(0), rand_field(0), rand_field(0));
        n_rand++;
      end
      mode = ($urandom_range(0, 7) < 2) ? $urandom_range(1, 2) : 0;
      len  = $urandom_range(10, 60);
      repeat (len) begin
        if ($urandom_range(0, 11) == 0)
          push_word(wcm_pkg::ACT_CLEAR, rand_field(0), rand_field(0), rand_field(0));
        else
          push_word(wcm_pkg::ACT_PUSH, rand_field(mode), rand_field(mode), rand_field(mode));
        if ($urandom_range(0, 39) == 0) push_drain();
      end
      n_rand += len;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (job_q.size() != 0 || in_ch.valid || cfg_ch.valid || mean_q.size() != 0)
      @(posedge clk);
    repeat (TAIL) @(posedge clk);

    if (n_err == 0 && mean_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> three_channel_window_mean_unit.f
design/wcm_pkg.sv
design/wcm_in_if.sv
design/wcm_out_if.sv
design/wcm_cfg_if.sv
design/wcm_store.sv
design/wcm_div.sv
design/three_channel_window_mean_unit.sv
tb/sv/tb_three_channel_window_mean_unit.sv
